/* design/lwks_pkg.sv */
package lwks_pkg;

  // sizes of the kernel matrix and the train window
  localparam int KERNEL_ROWS  = 64;
  localparam int KERNEL_COLS  = 64;
  localparam int WINDOW_DEPTH = 16;

  // derived address and count widths
  localparam int KADDR_W = $clog2(KERNEL_ROWS * KERNEL_COLS) > 0 ?
                           $clog2(KERNEL_ROWS * KERNEL_COLS) : 1;
  localparam int COL_AW  = $clog2(KERNEL_COLS) > 0 ? $clog2(KERNEL_COLS) : 1;
  localparam int WIN_AW  = $clog2(WINDOW_DEPTH) > 0 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W   = $clog2(WINDOW_DEPTH + 1);

  // operation codes
  localparam logic [1:0] OP_KERNEL = 2'd0;
  localparam logic [1:0] OP_TRAIN  = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] kernel_value;
    logic signed [31:0] weight;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [63:0] kernel_sum;
    logic               saturated;
  } result_t;

endpackage

/* design/local_weighted_kernel_sum.sv */
// Weighted bilinear kernel sum. Kernel entries (op 0) and train elements (op 1) are
// stored. Test elements (op 2) go through a three-stage read, multiply and accumulate
// pipeline and are taken one per cycle when not stalled; the last element of a test window
// stalls the input until it leaves the multiply stage, longer while the output register
// holds an unaccepted sum. The last train element stalls the input for a walk over all 64
// columns and all N stored train elements, one multiply per cycle through the train, kernel
// and column-sum memories. Column sums read as zero until the first walk writes them (a
// valid bit per column, cleared by reset). Result transfers may stall freely.
module local_weighted_kernel_sum (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  lwks_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output lwks_pkg::result_t   result
);

  typedef struct packed {
    logic               sat;
    logic signed [31:0] sum;
  } colsum_t;

  typedef struct packed {
    logic [5:0]         row;
    logic signed [31:0] weight;
  } train_t;

  // saturating 64-bit add, overflow flag in the top bit
  function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    logic               ovf;
    s   = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    if (ovf) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {ovf, s};
  endfunction

  function automatic logic [lwks_pkg::KADDR_W-1:0] kaddr(logic [5:0] r, logic [5:0] c);
    return lwks_pkg::KADDR_W'(int'(r) * lwks_pkg::KERNEL_COLS + int'(c));
  endfunction

  // memories
  logic signed [31:0] kernel_mem [lwks_pkg::KERNEL_ROWS * lwks_pkg::KERNEL_COLS];
  train_t             train_mem  [lwks_pkg::WINDOW_DEPTH];
  colsum_t            col_mem    [lwks_pkg::KERNEL_COLS];
  logic [lwks_pkg::KERNEL_COLS-1:0] col_valid;

  logic signed [31:0] kernel_q;
  train_t             train_q;
  colsum_t            col_q;

  logic [lwks_pkg::LEN_W-1:0]  train_length;
  logic [lwks_pkg::LEN_W-1:0]  len_next;

  // walk generator and pipeline
  logic                        gen_active;
  logic [lwks_pkg::COL_AW-1:0] gen_col;
  logic [lwks_pkg::WIN_AW-1:0] gen_j;
  logic [lwks_pkg::WIN_AW-1:0] gen_last_j;

  logic                        p1_valid, p1_first, p1_lastj;
  logic [lwks_pkg::COL_AW-1:0] p1_col;
  logic                        p2_valid, p2_first, p2_lastj, p2_row_ok;
  logic [lwks_pkg::COL_AW-1:0] p2_col;
  logic signed [31:0]          p2_weight;
  logic                        p3_valid, p3_first, p3_lastj;
  logic [lwks_pkg::COL_AW-1:0] p3_col;
  logic signed [63:0]          p3_prod;
  logic signed [63:0]          walk_sum;
  logic                        walk_sat;
  logic                        p4_done;
  logic [lwks_pkg::COL_AW-1:0] p4_col;
  logic                        walk_busy;

  // test pipeline
  logic                        s1_valid, s1_last, s1_col_ok;
  logic signed [31:0]          s1_weight;
  logic                        s2_valid, s2_last, s2_sat;
  logic signed [63:0]          s2_prod;
  logic signed [63:0]          test_acc;
  logic                        sat_seen;

  logic                        accept;
  logic                        col_ok_in, row_ok_in;
  logic [64:0]                 acc_add;
  logic                        acc_sat_next;
  logic                        slot_free;
  logic                        s2_advance;
  logic [64:0]                 walk_add;
  logic signed [48:0]          rnd;
  logic                        rnd_hi, rnd_lo;
  colsum_t                     col_wdata;
  logic signed [31:0]          cs;

  assign walk_busy  = gen_active || p1_valid || p2_valid || p3_valid || p4_done;
  assign item_stall = walk_busy || (s1_valid && s1_last) || (s2_valid && s2_last);
  assign accept     = item_valid && !item_stall;

  assign col_ok_in = int'(item.col_index) < lwks_pkg::KERNEL_COLS;
  assign row_ok_in = int'(item.row_index) < lwks_pkg::KERNEL_ROWS;
  assign len_next  = train_length + lwks_pkg::LEN_W'(1);

  // kernel memory: writes from op 0, reads from the walk
  always_ff @(posedge clk) begin
    if (accept && item.op == lwks_pkg::OP_KERNEL && row_ok_in && col_ok_in) begin
      kernel_mem[kaddr(item.row_index, item.col_index)] <= item.kernel_value;
    end
    kernel_q <= kernel_mem[kaddr(train_q.row, 6'(p1_col))];
  end

  // train memory: writes from op 1, reads from the walk generator
  always_ff @(posedge clk) begin
    if (accept && item.op == lwks_pkg::OP_TRAIN &&
        int'(train_length) < lwks_pkg::WINDOW_DEPTH) begin
      train_mem[train_length[lwks_pkg::WIN_AW-1:0]] <= '{row: item.row_index,
                                                          weight: item.weight};
    end
    train_q <= train_mem[gen_j];
  end

  // train length and walk generator
  always_ff @(posedge clk) begin
    if (rst) begin
      train_length <= '0;
      gen_active   <= 1'b0;
      gen_col      <= '0;
      gen_j        <= '0;
    end else if (accept && item.op == lwks_pkg::OP_TRAIN) begin
      if (item.last) begin
        train_length <= '0;
        gen_active   <= 1'b1;
        gen_col      <= '0;
        gen_j        <= '0;
      end else if (int'(train_length) < lwks_pkg::WINDOW_DEPTH) begin
        train_length <= len_next;
      end
    end else if (gen_active) begin
      if (gen_j == gen_last_j) begin
        gen_j <= '0;
        if (gen_col == lwks_pkg::COL_AW'(lwks_pkg::KERNEL_COLS - 1)) begin
          gen_active <= 1'b0;
        end else begin
          gen_col <= gen_col + lwks_pkg::COL_AW'(1);
        end
      end else begin
        gen_j <= gen_j + lwks_pkg::WIN_AW'(1);
      end
    end
  end

  // index of the last stored element of the closing window
  always_ff @(posedge clk) begin
    if (accept && item.op == lwks_pkg::OP_TRAIN && item.last) begin
      if (int'(train_length) < lwks_pkg::WINDOW_DEPTH) begin
        gen_last_j <= train_length[lwks_pkg::WIN_AW-1:0];
      end else begin
        gen_last_j <= lwks_pkg::WIN_AW'(lwks_pkg::WINDOW_DEPTH - 1);
      end
    end
  end

  // walk pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_done  <= 1'b0;
    end else begin
      p1_valid <= gen_active;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_done  <= p3_valid && p3_lastj;
    end
  end

  // walk pipeline payload: train read, kernel read, multiply, accumulate
  always_ff @(posedge clk) begin
    p1_col    <= gen_col;
    p1_first  <= (gen_j == '0);
    p1_lastj  <= (gen_j == gen_last_j);
    p2_col    <= p1_col;
    p2_first  <= p1_first;
    p2_lastj  <= p1_lastj;
    p2_weight <= train_q.weight;
    p2_row_ok <= int'(train_q.row) < lwks_pkg::KERNEL_ROWS;
    p3_col    <= p2_col;
    p3_first  <= p2_first;
    p3_lastj  <= p2_lastj;
    p3_prod   <= p2_row_ok ? 64'(p2_weight * kernel_q) : 64'sd0;
    if (p3_valid) begin
      if (p3_first) begin
        walk_sum <= p3_prod;
        walk_sat <= 1'b0;
      end else begin
        walk_sum <= walk_add[63:0];
        walk_sat <= walk_sat | walk_add[64];
      end
    end
    p4_col <= p3_col;
  end

  assign walk_add = sat_add(walk_sum, p3_prod);

  // round half up to q16.16 and saturate
  assign rnd    = 49'($signed(walk_sum[63:16])) + 49'({48'd0, walk_sum[15]});
  assign rnd_hi = rnd > 49'sd2147483647;
  assign rnd_lo = rnd < -49'sd2147483648;
  always_comb begin
    col_wdata.sat = walk_sat | rnd_hi | rnd_lo;
    if (rnd_hi) begin
      col_wdata.sum = 32'sh7fffffff;
    end else if (rnd_lo) begin
      col_wdata.sum = 32'sh80000000;
    end else begin
      col_wdata.sum = rnd[31:0];
    end
  end

  // column-sum memory: written by the walk, read by test elements
  always_ff @(posedge clk) begin
    if (p4_done) begin
      col_mem[p4_col] <= col_wdata;
    end
    if (accept) begin
      col_q <= col_mem[lwks_pkg::COL_AW'(item.col_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (p4_done) begin
      col_valid[p4_col] <= 1'b1;
    end
  end

  // test pipeline stage 1: column-sum read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && item.op == lwks_pkg::OP_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_weight <= item.weight;
      s1_last   <= item.last;
      s1_col_ok <= col_ok_in && col_valid[lwks_pkg::COL_AW'(item.col_index)];
    end
  end

  // test pipeline stage 2: multiply
  assign cs = s1_col_ok ? col_q.sum : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid) begin
      s2_valid <= 1'b1;
    end else if (s2_advance) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_prod <= 64'(cs * s1_weight);
      s2_sat  <= s1_col_ok && col_q.sat;
      s2_last <= s1_last;
    end
  end

  // accumulate, and on the window's last element move the sum to the output
  assign slot_free    = !result_valid || !result_stall;
  assign s2_advance   = s2_valid && (!s2_last || slot_free);
  assign acc_add      = sat_add(test_acc, s2_prod);
  assign acc_sat_next = sat_seen | s2_sat | acc_add[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      test_acc     <= '0;
      sat_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s2_advance && s2_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (s2_advance) begin
        if (s2_last) begin
          test_acc     <= '0;
          sat_seen     <= 1'b0;
        end else begin
          test_acc     <= acc_add[63:0];
          sat_seen     <= acc_sat_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance && s2_last) begin
      result.kernel_sum <= acc_add[63:0];
      result.saturated  <= acc_sat_next;
    end
  end

endmodule

/* verif/local_weighted_kernel_sum_test.sv */
module local_weighted_kernel_sum_test;

  // op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // fixed point limits and handy values
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam longint COL_MAX = 64'sd2147483647;
  localparam longint COL_MIN = -64'sd2147483648;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  localparam int RANDOM_ITEMS = 930;
  localparam int SETTLE_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  lwks_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  lwks_pkg::result_t result;

  local_weighted_kernel_sum dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #4 clk = ~clk;

  // predicted block state
  logic signed [31:0] kernel_copy [lwks_pkg::KERNEL_ROWS][lwks_pkg::KERNEL_COLS];
  bit                 entry_set [lwks_pkg::KERNEL_ROWS][lwks_pkg::KERNEL_COLS];
  bit                 row_done [lwks_pkg::KERNEL_ROWS];
  int                 ready_rows [$];
  logic [5:0]         win_row [lwks_pkg::WINDOW_DEPTH];
  logic signed [31:0] win_weight [lwks_pkg::WINDOW_DEPTH];
  int                 win_len;
  logic signed [31:0] column_sum [lwks_pkg::KERNEL_COLS];
  bit                 column_sat [lwks_pkg::KERNEL_COLS];
  longint             window_acc;
  bit                 window_sat;
  lwks_pkg::result_t  sums_pending [$];

  int mismatches = 0;
  int quiet_left = 0;
  int stall_left = 0;
  bit stall_now;
  bit valid_up = 1'b0;

  function automatic void clear_prediction();
    int c;
    win_len = 0;
    window_acc = 0;
    window_sat = 1'b0;
    for (c = 0; c < lwks_pkg::KERNEL_COLS; c++) begin
      column_sum[c] = '0;
      column_sat[c] = 1'b0;
    end
  endfunction

  function automatic longint sat_add(input longint a, input longint b, output bit ovf);
    longint s;
    s = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    if (!ovf) return s;
    return a[63] ? SUM_MIN : SUM_MAX;
  endfunction

  // recompute every column sum over the stored train elements
  function automatic void walk_columns();
    int c, j;
    longint s, p, q, wt, kv;
    bit ovf, sat;
    for (c = 0; c < lwks_pkg::KERNEL_COLS; c++) begin
      s = 0;
      sat = 1'b0;
      for (j = 0; j < win_len; j++) begin
        wt = win_weight[j];
        kv = kernel_copy[win_row[j]][c];
        p = wt * kv;
        s = sat_add(s, p, ovf);
        sat |= ovf;
      end
      // round half up to q16.16, then clamp to 32 bits
      q = (s >>> 16) + ((s >>> 15) & 64'sd1);
      if (q > COL_MAX) begin
        q = COL_MAX;
        sat = 1'b1;
      end
      if (q < COL_MIN) begin
        q = COL_MIN;
        sat = 1'b1;
      end
      column_sum[c] = q[31:0];
      column_sat[c] = sat;
    end
    win_len = 0;
  endfunction

  function automatic void predict_kernel_sum(lwks_pkg::item_t it);
    longint cs, wt, p;
    bit ovf, full;
    int c;
    case (it.op)
      lwks_pkg::OP_KERNEL: begin
        kernel_copy[it.row_index][it.col_index] = it.kernel_value;
        entry_set[it.row_index][it.col_index] = 1'b1;
        // a row is usable for train elements once every column is written
        if (!row_done[it.row_index]) begin
          full = 1'b1;
          for (c = 0; c < lwks_pkg::KERNEL_COLS; c++) full &= entry_set[it.row_index][c];
          if (full) begin
            row_done[it.row_index] = 1'b1;
            ready_rows.push_back(it.row_index);
          end
        end
      end
      lwks_pkg::OP_TRAIN: begin
        if (win_len < lwks_pkg::WINDOW_DEPTH) begin
          win_row[win_len] = it.row_index;
          win_weight[win_len] = it.weight;
          win_len++;
        end
        if (it.last) walk_columns();
      end
      lwks_pkg::OP_TEST: begin
        cs = column_sum[it.col_index];
        if (column_sat[it.col_index]) window_sat = 1'b1;
        wt = it.weight;
        p = cs * wt;
        window_acc = sat_add(window_acc, p, ovf);
        window_sat |= ovf;
        if (it.last) begin
          lwks_pkg::result_t r;
          r.kernel_sum = window_acc;
          r.saturated = window_sat;
          sums_pending.push_back(r);
          window_acc = 0;
          window_sat = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result(input lwks_pkg::result_t got);
    lwks_pkg::result_t want;
    if (sums_pending.size() == 0) begin
      report_mismatch($sformatf("sum %0d with none expected", got.kernel_sum));
      return;
    end
    want = sums_pending.pop_front();
    if (got.kernel_sum !== want.kernel_sum)
      report_mismatch($sformatf("kernel_sum %0d, expected %0d", got.kernel_sum,
                                want.kernel_sum));
    if (got.saturated !== want.saturated)
      report_mismatch($sformatf("saturated %0b, expected %0b", got.saturated,
                                want.saturated));
  endtask

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // sender gap, with occasional stretches of back-to-back transfers
  function automatic int pick_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return 1 + pick_len();
  endfunction

  function automatic logic signed [31:0] small_q();
    int v;
    v = $urandom_range(0, 262143);
    return v - 131072;
  endfunction

  function automatic logic signed [31:0] rand_q();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4, 5, 6, 7: return $urandom();
      default: return small_q();
    endcase
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic lwks_pkg::item_t make_item(input logic [1:0] op, input int row,
                                                input int col,
                                                input logic signed [31:0] kval,
                                                input logic signed [31:0] w, input bit last);
    lwks_pkg::item_t it;
    it.op = op;
    it.row_index = row[5:0];
    it.col_index = col[5:0];
    it.kernel_value = kval;
    it.weight = w;
    it.last = last;
    return it;
  endfunction

  function automatic int pick_ready_row();
    return ready_rows[$urandom_range(0, ready_rows.size() - 1)];
  endfunction

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) check_result(result);
    if (stall_left <= 0) begin
      stall_now = ($urandom_range(0, 2) == 0);
      if (stall_now) stall_left = 1 + pick_len();
      else if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(100, 300);
      else stall_left = 1 + 2 * pick_len();
      result_stall <= stall_now;
    end
    stall_left--;
  end

  task automatic lower_valid();
    if (valid_up) begin
      item_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // one input transfer, predicted at the edge that takes it
  task automatic send_item(input lwks_pkg::item_t it);
    int gap;
    item <= it;
    item_valid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    predict_kernel_sum(it);
    gap = pick_gap();
    if (gap > 0) begin
      lower_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    lower_valid();
    do @(posedge clk); while (sums_pending.size() != 0);
  endtask

  // column sums read as zero before any train window closes
  task automatic test_idle_sums();
    send_item(make_item(lwks_pkg::OP_TEST, 0, 0, '0, Q_MAX, 1'b0));
    send_item(make_item(OP_UNUSED, 63, 63, '1, '1, 1'b1));
    send_item(make_item(lwks_pkg::OP_TEST, 63, 63, Q_MAX, Q_MIN, 1'b1));
  endtask

  // full rows: row 0 at the maximum, row 63 at the minimum, a few random
  task automatic test_kernel_load();
    int r, c;
    for (c = 0; c < lwks_pkg::KERNEL_COLS; c++)
      send_item(make_item(lwks_pkg::OP_KERNEL, 0, c, Q_MAX, '0, 1'b0));
    for (c = lwks_pkg::KERNEL_COLS - 1; c >= 0; c--)
      send_item(make_item(lwks_pkg::OP_KERNEL, 63, c, Q_MIN, '1, 1'b1));
    for (r = 1; r <= 4; r++)
      for (c = 0; c < lwks_pkg::KERNEL_COLS; c++)
        send_item(make_item(lwks_pkg::OP_KERNEL, r, c, rand_q(), rand_q(), rand_bit()));
  endtask

  // accumulation and column saturation
  task automatic test_saturation();
    send_item(make_item(lwks_pkg::OP_TRAIN, 0, 0, '0, Q_ONE, 1'b1));
    send_item(make_item(lwks_pkg::OP_TEST, 0, 5, '0, Q_MAX, 1'b0));
    send_item(make_item(lwks_pkg::OP_TEST, 0, 9, '0, Q_MAX, 1'b0));
    send_item(make_item(lwks_pkg::OP_TEST, 0, 40, '0, Q_MAX, 1'b1));
    // two min by min products overflow the 64-bit column sum
    send_item(make_item(lwks_pkg::OP_TRAIN, 63, 0, '0, Q_MIN, 1'b0));
    send_item(make_item(lwks_pkg::OP_TRAIN, 63, 0, '0, Q_MIN, 1'b0));
    send_item(make_item(lwks_pkg::OP_TRAIN, 0, 0, '0, Q_MIN, 1'b1));
    send_item(make_item(lwks_pkg::OP_TEST, 0, 12, '0, Q_ONE, 1'b1));
  endtask

  // elements past the window depth are dropped, last still closes
  task automatic test_window_overflow();
    int j;
    for (j = 0; j <= lwks_pkg::WINDOW_DEPTH; j++)
      send_item(make_item(lwks_pkg::OP_TRAIN, pick_ready_row(), $urandom_range(0, 63),
                          rand_q(), small_q(), j == lwks_pkg::WINDOW_DEPTH));
    send_item(make_item(lwks_pkg::OP_TEST, 0, 31, '0, Q_ONE, 1'b1));
  endtask

  // mostly complete windows with random content, some noise and open windows
  task automatic test_random_mix();
    int done_items, n, j, r;
    int unsigned kind;
    bit drained, broken;
    done_items = 0;
    drained = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      if (!drained && done_items > RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      broken = ($urandom_range(0, 19) == 0);
      if (kind < 15) begin
        n = $urandom_range(1, 8);
        for (j = 0; j < n; j++)
          send_item(make_item(lwks_pkg::OP_KERNEL, $urandom_range(0, 63),
                              $urandom_range(0, 63), rand_q(), rand_q(), rand_bit()));
        done_items += n;
      end else if (kind < 16) begin
        r = $urandom_range(0, 63);
        for (j = 0; j < lwks_pkg::KERNEL_COLS; j++)
          send_item(make_item(lwks_pkg::OP_KERNEL, r, j, rand_q(), rand_q(), rand_bit()));
        done_items += lwks_pkg::KERNEL_COLS;
      end else if (kind < 36) begin
        r = $urandom_range(0, 9);
        if (r < 6) n = $urandom_range(1, 4);
        else if (r < 9) n = $urandom_range(5, lwks_pkg::WINDOW_DEPTH);
        else n = $urandom_range(lwks_pkg::WINDOW_DEPTH + 1, lwks_pkg::WINDOW_DEPTH + 4);
        for (j = 0; j < n; j++)
          send_item(make_item(lwks_pkg::OP_TRAIN, pick_ready_row(), $urandom_range(0, 63),
                              rand_q(), rand_q(), (j == n - 1) && !broken));
        done_items += n;
      end else if (kind < 92) begin
        n = $urandom_range(1, 10);
        for (j = 0; j < n; j++)
          send_item(make_item(lwks_pkg::OP_TEST, $urandom_range(0, 63),
                              $urandom_range(0, 63), rand_q(), rand_q(),
                              (j == n - 1) && !broken));
        done_items += n;
      end else begin
        send_item(make_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom(), $urandom(), rand_bit()));
        done_items++;
      end
    end
    // close with a complete test window so nothing is left in flight
    send_item(make_item(lwks_pkg::OP_TEST, 0, $urandom_range(0, 63), '0, rand_q(), 1'b1));
  endtask

  task automatic finish_run();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("local_weighted_kernel_sum regression: pass");
    else $display("local_weighted_kernel_sum regression: fail");
    $finish;
  endtask

  initial begin
    clear_prediction();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_sums();
    test_kernel_load();
    test_saturation();
    test_window_overflow();
    test_random_mix();
    finish_run();
  end

  // run limit
  initial begin
    #8_000_000;
    $display("local_weighted_kernel_sum regression: fail");
    $finish;
  end

endmodule
